### rtl/core/omrc_pkg.sv
// Shared types and constants of the offset multiset rank counter.
`default_nettype none

package omrc_pkg;

  // Width of the value field on the input item and of the sign-extended form.
  localparam int unsigned IN_VALUE_W = 48;
  localparam int unsigned EXT_W      = 64;
  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_ADD    = 3'd2,
    OP_COUNT  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  // Control part of an item as it travels down the row of cells.
  typedef struct packed {
    logic vld;
    op_e  op;
    logic hit;
  } ctl_t;

endpackage

`default_nettype wire

### rtl/core/omrc_front.sv
// Entry stage: decodes the operation, holds the global offset, forms the relative value.
`default_nettype none

module omrc_front #(
  parameter int unsigned VALUE_WIDTH = 48
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                adv_i,
  input  wire logic                                in_vld_i,
  input  wire logic [omrc_pkg::FUNC_W-1:0]         func_i,
  input  wire logic [omrc_pkg::IN_VALUE_W-1:0]     value_i,
  output omrc_pkg::ctl_t                           ctl_o,
  output logic [VALUE_WIDTH-1:0]                   val_o
);
  import omrc_pkg::*;

  logic [EXT_W-1:0]       v_ext;
  logic [VALUE_WIDTH-1:0] v_w;
  logic [VALUE_WIDTH-1:0] amt;
  logic [VALUE_WIDTH-1:0] rel;
  logic [VALUE_WIDTH-1:0] off_q, off_d;
  logic                   is_nop;
  op_e                    op;
  ctl_t                   ctl_q;
  logic [VALUE_WIDTH-1:0] val_q;

  assign v_ext = {{(EXT_W - IN_VALUE_W){value_i[IN_VALUE_W-1]}}, value_i};
  assign v_w   = v_ext[VALUE_WIDTH-1:0];

  // Unused function codes travel as an add of zero, which changes nothing.
  always_comb begin
    is_nop = (func_i > OP_CLEAR);
    op     = is_nop ? OP_ADD : op_e'(func_i);
    amt    = is_nop ? '0 : v_w;
    rel    = v_w - off_q;
    off_d  = off_q;
    if (adv_i && in_vld_i) begin
      case (op)
        OP_ADD:   off_d = off_q + amt;
        OP_CLEAR: off_d = '0;
        default:  off_d = off_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      ctl_q <= '0;
    end else begin
      off_q <= off_d;
      if (adv_i) begin
        ctl_q <= '{vld: in_vld_i, op: op, hit: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      val_q <= rel;
    end
  end

  assign ctl_o = ctl_q;
  assign val_o = val_q;

endmodule

`default_nettype wire

### rtl/core/omrc_cell.sv
// One cell of the row: holds one entry and passes each item on to its neighbor.
`default_nettype none

module omrc_cell #(
  parameter int unsigned VALUE_WIDTH = 48,
  parameter int unsigned CNT_W       = 11
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    adv_i,
  input  wire omrc_pkg::ctl_t          ctl_i,
  input  wire logic [VALUE_WIDTH-1:0]  val_i,
  input  wire logic [CNT_W-1:0]        cnt_i,
  output omrc_pkg::ctl_t               ctl_o,
  output logic [VALUE_WIDTH-1:0]       val_o,
  output logic [CNT_W-1:0]             cnt_o
);
  import omrc_pkg::*;

  logic [VALUE_WIDTH-1:0] ent_q, ent_d;
  logic                   used_q, used_d;
  ctl_t                   ctl_d, ctl_q;
  logic [CNT_W-1:0]       cnt_d, cnt_q;
  logic [VALUE_WIDTH-1:0] val_q;

  always_comb begin
    ent_d  = ent_q;
    used_d = used_q;
    ctl_d  = ctl_i;
    cnt_d  = cnt_i;
    if (ctl_i.vld) begin
      case (ctl_i.op)
        OP_INSERT: begin
          if (!ctl_i.hit && !used_q) begin
            ent_d     = val_i;
            used_d    = 1'b1;
            ctl_d.hit = 1'b1;
          end
        end
        OP_ERASE: begin
          if (!ctl_i.hit && used_q && (ent_q == val_i)) begin
            used_d    = 1'b0;
            ctl_d.hit = 1'b1;
          end
        end
        OP_COUNT: begin
          if (used_q && ($signed(ent_q) < $signed(val_i))) begin
            cnt_d = cnt_i + CNT_W'(1);
          end
        end
        OP_CLEAR: used_d = 1'b0;
        default:  used_d = used_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      ctl_q  <= '0;
    end else if (adv_i) begin
      used_q <= used_d;
      ctl_q  <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ent_q <= ent_d;
      val_q <= val_i;
      cnt_q <= cnt_d;
    end
  end

  assign ctl_o = ctl_q;
  assign val_o = val_q;
  assign cnt_o = cnt_q;

endmodule

`default_nettype wire

### rtl/core/offset_multiset_rank_counter.sv
// Top level of the offset multiset rank counter: entry stage, row of cells, result stage.
//
// Items arrive on the s_axis channel, one operation each: insert, erase one copy,
// add to all, count values below, or clear. Every item gives exactly one result
// item on the m_axis channel with the count, a status and the occupancy after it.
// An item passes through the entry register, then one cell per cycle (while the row is not
// held) along a row of CAPACITY cells, each holding one entry, and lands in the output register.
// The row is a pipeline, so one item is accepted every cycle unless a waiting result holds it,
// and items stay in order.
// The global offset lives in the entry stage, so values travel in relative form.
// Reset empties every cell, zeroes the offset and occupancy, and leaves no item
// in flight. While a result waits with m_axis_tready_i low, the whole row holds
// still and s_axis_tready_o stays low; once it is taken, the row moves again.
`default_nettype none

module offset_multiset_rank_counter #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned VALUE_WIDTH = 48,
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1),
  localparam int unsigned OUT_RAW_W  = 2 * CNT_W + omrc_pkg::STATUS_W,
  localparam int unsigned OUT_W      = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // Fields from bit 0 up: func (3), value (48), zero padding.
  input  wire logic [55:0]       s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // Fields from bit 0 up: count, status (2), occupancy, zero padding.
  output logic [OUT_W-1:0]       m_axis_tdata_o
);
  import omrc_pkg::*;

  logic                    adv;
  ctl_t                    ctl_c [CAPACITY+1];
  logic [VALUE_WIDTH-1:0]  val_c [CAPACITY+1];
  logic [CNT_W-1:0]        cnt_c [CAPACITY+1];

  logic [CNT_W-1:0]        occ_q, occ_d;
  status_e                 st;
  logic                    out_vld_q;
  logic [CNT_W-1:0]        out_cnt_q, out_cnt_d;
  status_e                 out_st_q;
  logic [CNT_W-1:0]        out_occ_q;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  omrc_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .in_vld_i(s_axis_tvalid_i),
    .func_i  (s_axis_tdata_i[FUNC_W-1:0]),
    .value_i (s_axis_tdata_i[FUNC_W+IN_VALUE_W-1:FUNC_W]),
    .ctl_o   (ctl_c[0]),
    .val_o   (val_c[0])
  );

  assign cnt_c[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    omrc_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .ctl_i (ctl_c[g]),
      .val_i (val_c[g]),
      .cnt_i (cnt_c[g]),
      .ctl_o (ctl_c[g+1]),
      .val_o (val_c[g+1]),
      .cnt_o (cnt_c[g+1])
    );
  end

  always_comb begin
    st        = ST_OK;
    occ_d     = occ_q;
    out_cnt_d = '0;
    if (ctl_c[CAPACITY].vld) begin
      case (ctl_c[CAPACITY].op)
        OP_INSERT: begin
          if (ctl_c[CAPACITY].hit) begin
            occ_d = occ_q + CNT_W'(1);
          end else begin
            st = ST_FULL;
          end
        end
        OP_ERASE: begin
          if (ctl_c[CAPACITY].hit) begin
            occ_d = occ_q - CNT_W'(1);
          end else begin
            st = ST_MISSING;
          end
        end
        OP_COUNT: out_cnt_d = cnt_c[CAPACITY];
        OP_CLEAR: occ_d = '0;
        default:  occ_d = occ_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      occ_q     <= occ_d;
      out_vld_q <= ctl_c[CAPACITY].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_cnt_q <= out_cnt_d;
      out_st_q  <= st;
      out_occ_q <= occ_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_W'({out_occ_q, out_st_q, out_cnt_q});

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(CAPACITY))
    else $error("Occupancy exceeds capacity.");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_st_q == ST_FULL)) |-> (out_occ_q == CNT_W'(CAPACITY)))
    else $error("Insert dropped while the store was not full.");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_cnt_q <= out_occ_q))
    else $error("Count exceeds the number of held values.");

  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(ctl_c[CAPACITY]) && $stable(occ_q))
    else $error("Row moved while the result was stalled.");
`endif

endmodule

`default_nettype wire

### tb/sv/offset_multiset_rank_counter_tb.sv
// Self-checking testbench for the offset multiset rank counter, with a shadow multiset as predictor.
`default_nettype none

module offset_multiset_rank_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import omrc_pkg::*;

  localparam int unsigned CAP      = 1024;
  localparam int unsigned VAL_W    = 48;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned RX_LIMIT = 10;

  localparam logic [2:0] FUNC_RSVD_5 = 3'd5;
  localparam logic [2:0] FUNC_RSVD_6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD_7 = 3'd7;

  localparam logic [VAL_W-1:0] MAX_POS  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] MIN_NEG  = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] ALT_01   = {(VAL_W/2){2'b01}};
  localparam logic [VAL_W-1:0] ALT_10   = {(VAL_W/2){2'b10}};

  // Packed from the top down so that count lands in the lowest bits, as on m_axis_tdata_o.
  typedef struct packed {
    logic [CNT_W-1:0] occupancy;
    status_e          status;
    logic [CNT_W-1:0] count;
  } result_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_valid  = 1'b0;
  logic [55:0] s_data   = '0;
  logic        m_ready  = 1'b0;
  logic        idle_en  = 1'b1;
  logic        hold_off = 1'b0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [23:0] m_axis_tdata_o;

  logic [VAL_W-1:0] shadow_rel [CAP];
  int unsigned      shadow_fill   = 0;
  logic [VAL_W-1:0] shadow_offset = '0;
  result_t          pending_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      rx_gap = 0;

  offset_multiset_rank_counter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic result_t apply_to_shadow_set(input logic [2:0] func,
                                                  input logic [VAL_W-1:0] value);
    result_t          res;
    logic [VAL_W-1:0] rel;
    int unsigned      i;
    bit               found;
    res           = '0;
    res.status    = ST_OK;
    found         = 1'b0;
    rel           = value - shadow_offset;
    case (func)
      OP_INSERT: begin
        if (shadow_fill == CAP) begin
          res.status = ST_FULL;
        end else begin
          shadow_rel[shadow_fill] = rel;
          shadow_fill++;
        end
      end
      OP_ERASE: begin
        for (i = 0; i < shadow_fill && !found; i++) begin
          if (shadow_rel[i] == rel) begin
            shadow_rel[i] = shadow_rel[shadow_fill-1];
            shadow_fill--;
            found = 1'b1;
          end
        end
        if (!found) res.status = ST_MISSING;
      end
      OP_ADD: shadow_offset = shadow_offset + value;
      OP_COUNT: begin
        for (i = 0; i < shadow_fill; i++) begin
          if ($signed(shadow_rel[i]) < $signed(rel)) res.count++;
        end
      end
      OP_CLEAR: begin
        shadow_fill   = 0;
        shadow_offset = '0;
      end
      default: ;
    endcase
    res.occupancy = CNT_W'(shadow_fill);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= RX_LIMIT)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Result side: check every accepted item, then pick the next ready level.
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (m_axis_tvalid_o && m_ready) begin
      got = result_t'(m_axis_tdata_o);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= RX_LIMIT) $display("unexpected result item %h", m_axis_tdata_o);
      end else begin
        want = pending_results.pop_front();
        check_field("count", want.count, got.count);
        check_field("status", CNT_W'(want.status), CNT_W'(got.status));
        check_field("occupancy", want.occupancy, got.occupancy);
      end
    end
    if (hold_off) begin
      m_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 4);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [2:0] func, input logic [VAL_W-1:0] value);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {5'b0, value, func};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.insert(pending_results.size(), apply_to_shadow_set(func, value));
  endtask

  task automatic wait_results_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_W'({$urandom, $urandom});
      1: begin
        case ($urandom_range(0, 3))
          0: return MAX_POS;
          1: return MIN_NEG;
          2: return ALL_ONES;
          default: return '0;
        endcase
      end
      default: return VAL_W'(int'($urandom_range(0, 12)) - 6);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_stored_value();
    if (shadow_fill == 0) return pick_value();
    return shadow_rel[$urandom_range(0, shadow_fill - 1)] + shadow_offset;
  endfunction

  task automatic test_directed_edges();
    send_item(OP_COUNT, '0);
    send_item(OP_ERASE, '0);
    send_item(OP_INSERT, MAX_POS);
    send_item(OP_INSERT, MIN_NEG);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, ALL_ONES);
    send_item(OP_INSERT, '0);
    send_item(OP_COUNT, '0);
    send_item(OP_COUNT, MAX_POS);
    send_item(OP_COUNT, MIN_NEG);
    send_item(OP_ERASE, '0);
    send_item(OP_ERASE, VAL_W'(5));
    send_item(OP_ADD, VAL_W'(1));
    send_item(OP_COUNT, MIN_NEG);
    send_item(OP_ERASE, VAL_W'(1));
    send_item(OP_ADD, MAX_POS);
    send_item(OP_ADD, MIN_NEG);
    send_item(OP_COUNT, ALT_01);
    send_item(FUNC_RSVD_5, ALL_ONES);
    send_item(FUNC_RSVD_6, ALT_10);
    send_item(FUNC_RSVD_7, ALL_ONES);
    send_item(OP_CLEAR, ALL_ONES);
    send_item(OP_COUNT, MAX_POS);
    send_item(OP_INSERT, ALT_01);
    send_item(OP_ERASE, ALT_01);
  endtask

  // The result side holds off long enough for the row to fill and stall the input,
  // while the set is filled to capacity and inserts past that are dropped.
  task automatic test_fill_under_backpressure();
    int unsigned i;
    fork
      begin
        hold_off <= 1'b1;
        repeat (4000) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      begin
        send_item(OP_CLEAR, '0);
        send_item(OP_ADD, pick_value());
        for (i = 0; i < CAP; i++) send_item(OP_INSERT, pick_value());
        send_item(OP_INSERT, MAX_POS);
        send_item(OP_INSERT, '0);
        send_item(OP_COUNT, '0);
        send_item(OP_COUNT, MAX_POS);
        send_item(OP_COUNT, MIN_NEG);
        send_item(OP_ERASE, pick_stored_value());
        send_item(OP_INSERT, MIN_NEG);
        send_item(OP_INSERT, ALL_ONES);
        send_item(OP_COUNT, pick_stored_value());
        send_item(OP_CLEAR, '0);
      end
    join
  endtask

  task automatic test_random_mix(input int unsigned n_items);
    int unsigned i;
    int unsigned r;
    for (i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_item(OP_INSERT, pick_value());
      end else if (r < 55) begin
        send_item(OP_ERASE, ($urandom_range(0, 9) < 7) ? pick_stored_value() : pick_value());
      end else if (r < 65) begin
        send_item(OP_ADD, ($urandom_range(0, 3) == 0) ? pick_value()
                                                        : VAL_W'(int'($urandom_range(0, 6)) - 3));
      end else if (r < 90) begin
        send_item(OP_COUNT, ($urandom_range(0, 1) == 0) ? pick_stored_value() : pick_value());
      end else if (r < 93) begin
        send_item(OP_CLEAR, VAL_W'({$urandom, $urandom}));
      end else if (r < 96) begin
        case ($urandom_range(0, 2))
          0: send_item(FUNC_RSVD_5, VAL_W'({$urandom, $urandom}));
          1: send_item(FUNC_RSVD_6, VAL_W'({$urandom, $urandom}));
          default: send_item(FUNC_RSVD_7, VAL_W'({$urandom, $urandom}));
        endcase
      end else begin
        send_item(OP_ERASE, VAL_W'({$urandom, $urandom}));
      end
    end
  endtask

  task automatic test_sender_pause();
    test_random_mix(20);
    wait_results_drained();
    test_random_mix(20);
    wait_results_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_fill_under_backpressure();
    test_random_mix(350);
    test_sender_pause();
    idle_en <= 1'b0;
    test_random_mix(120);
    wait_results_drained();
    repeat (CAP + 16) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
